>>> sv/dqtp_pkg.sv
package dqtp_pkg;

  // Marker bytes and masks of the DQT segment.
  localparam logic [7:0] MARK_FF     = 8'hFF;
  localparam logic [7:0] MARK_DQT    = 8'hDB;
  localparam logic [7:0] ID_MASK     = 8'h0F;
  localparam logic [7:0] PREC_MASK   = 8'hF0;
  localparam int         TABLE_LEN   = 64;
  localparam logic [15:0] NEED_NARROW = 16'(TABLE_LEN);
  localparam logic [15:0] NEED_WIDE   = 16'(2 * TABLE_LEN);
  localparam logic [5:0]  ZZ_LAST     = 6'(TABLE_LEN - 1);

  // Result status codes.
  localparam logic [1:0] ST_ENTRY   = 2'd0;
  localparam logic [1:0] ST_BAD_MRK = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MARK2 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_INFO  = 3'd4,
    PH_ENTRY = 3'd5,
    PH_LOW   = 3'd6
  } phase_t;

  // One result item as it travels from the parser to the output queue.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  table_id;
    logic [5:0]  entry_index;
    logic [15:0] entry_value;
    logic        table_last;
    logic        segment_last;
  } result_t;

  // Natural (row-major) index of each zigzag position.
  function automatic logic [5:0] natural_of_zz(input logic [5:0] zz);
    logic [5:0] idx;
    case (zz)
      6'd0:  idx = 6'd0;   6'd1:  idx = 6'd1;   6'd2:  idx = 6'd8;   6'd3:  idx = 6'd16;
      6'd4:  idx = 6'd9;   6'd5:  idx = 6'd2;   6'd6:  idx = 6'd3;   6'd7:  idx = 6'd10;
      6'd8:  idx = 6'd17;  6'd9:  idx = 6'd24;  6'd10: idx = 6'd32;  6'd11: idx = 6'd25;
      6'd12: idx = 6'd18;  6'd13: idx = 6'd11;  6'd14: idx = 6'd4;   6'd15: idx = 6'd5;
      6'd16: idx = 6'd12;  6'd17: idx = 6'd19;  6'd18: idx = 6'd26;  6'd19: idx = 6'd33;
      6'd20: idx = 6'd40;  6'd21: idx = 6'd48;  6'd22: idx = 6'd41;  6'd23: idx = 6'd34;
      6'd24: idx = 6'd27;  6'd25: idx = 6'd20;  6'd26: idx = 6'd13;  6'd27: idx = 6'd6;
      6'd28: idx = 6'd7;   6'd29: idx = 6'd14;  6'd30: idx = 6'd21;  6'd31: idx = 6'd28;
      6'd32: idx = 6'd35;  6'd33: idx = 6'd42;  6'd34: idx = 6'd49;  6'd35: idx = 6'd56;
      6'd36: idx = 6'd57;  6'd37: idx = 6'd50;  6'd38: idx = 6'd43;  6'd39: idx = 6'd36;
      6'd40: idx = 6'd29;  6'd41: idx = 6'd22;  6'd42: idx = 6'd15;  6'd43: idx = 6'd23;
      6'd44: idx = 6'd30;  6'd45: idx = 6'd37;  6'd46: idx = 6'd44;  6'd47: idx = 6'd51;
      6'd48: idx = 6'd58;  6'd49: idx = 6'd59;  6'd50: idx = 6'd52;  6'd51: idx = 6'd45;
      6'd52: idx = 6'd38;  6'd53: idx = 6'd31;  6'd54: idx = 6'd39;  6'd55: idx = 6'd46;
      6'd56: idx = 6'd53;  6'd57: idx = 6'd60;  6'd58: idx = 6'd61;  6'd59: idx = 6'd54;
      6'd60: idx = 6'd47;  6'd61: idx = 6'd55;  6'd62: idx = 6'd62;  6'd63: idx = 6'd63;
      default: idx = 6'd0;
    endcase
    return idx;
  endfunction

endpackage

>>> sv/dqtp_parse.sv
// Front end: takes one segment byte per accepted beat, advances the parse
// state and produces at most one result in the same cycle.
module dqtp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_en,      // a byte is accepted this cycle
  input  logic [7:0]        seg_byte,
  input  logic              seg_start,
  output logic              res_valid,
  output dqtp_pkg::result_t res
);

  dqtp_pkg::phase_t phase, phase_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [3:0]  current_table, current_table_next;
  logic        wide_entries, wide_entries_next;
  logic [5:0]  zigzag_position, zigzag_position_next;
  logic [7:0]  high_byte, high_byte_next;

  // Shared terms of the datapath.
  logic [15:0] rem_dec;
  logic [15:0] seg_len;
  logic [3:0]  info_id;
  logic        info_wide;
  logic        info_overrun;
  logic        tab_end;

  assign rem_dec      = (bytes_remaining != 16'd0) ? bytes_remaining - 16'd1 : bytes_remaining;
  assign seg_len      = {high_byte, seg_byte};
  assign info_id      = 4'(seg_byte & dqtp_pkg::ID_MASK);
  assign info_wide    = (seg_byte & dqtp_pkg::PREC_MASK) != 8'd0;
  assign info_overrun = rem_dec < (info_wide ? dqtp_pkg::NEED_WIDE : dqtp_pkg::NEED_NARROW);
  assign tab_end      = zigzag_position == dqtp_pkg::ZZ_LAST;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (seg_start) begin
      phase_next = (seg_byte == dqtp_pkg::MARK_FF) ? dqtp_pkg::PH_MARK2 : dqtp_pkg::PH_IDLE;
    end else begin
      case (phase)
        dqtp_pkg::PH_IDLE: phase_next = dqtp_pkg::PH_IDLE;
        dqtp_pkg::PH_MARK2: begin
          phase_next = (seg_byte == dqtp_pkg::MARK_DQT) ? dqtp_pkg::PH_LENHI
                                                        : dqtp_pkg::PH_IDLE;
        end
        dqtp_pkg::PH_LENHI: phase_next = dqtp_pkg::PH_LENLO;
        dqtp_pkg::PH_LENLO: begin
          phase_next = (seg_len > 16'd2) ? dqtp_pkg::PH_INFO : dqtp_pkg::PH_IDLE;
        end
        dqtp_pkg::PH_INFO: begin
          phase_next = info_overrun ? dqtp_pkg::PH_IDLE : dqtp_pkg::PH_ENTRY;
        end
        dqtp_pkg::PH_ENTRY, dqtp_pkg::PH_LOW: begin
          if (phase == dqtp_pkg::PH_ENTRY && wide_entries) begin
            phase_next = dqtp_pkg::PH_LOW;
          end else if (tab_end) begin
            phase_next = (rem_dec == 16'd0) ? dqtp_pkg::PH_IDLE : dqtp_pkg::PH_INFO;
          end else begin
            phase_next = dqtp_pkg::PH_ENTRY;
          end
        end
        default: phase_next = dqtp_pkg::PH_IDLE;
      endcase
    end
  end

  // Results and datapath updates.
  always_comb begin
    res_valid             = 1'b0;
    res                   = '0;
    bytes_remaining_next  = bytes_remaining;
    current_table_next    = current_table;
    wide_entries_next     = wide_entries;
    zigzag_position_next  = zigzag_position;
    high_byte_next        = high_byte;
    if (seg_start) begin
      if (seg_byte != dqtp_pkg::MARK_FF) begin
        res_valid  = 1'b1;
        res.status = dqtp_pkg::ST_BAD_MRK;
      end
    end else begin
      case (phase)
        dqtp_pkg::PH_MARK2: begin
          if (seg_byte != dqtp_pkg::MARK_DQT) begin
            res_valid  = 1'b1;
            res.status = dqtp_pkg::ST_BAD_MRK;
          end
        end
        dqtp_pkg::PH_LENHI: high_byte_next = seg_byte;
        dqtp_pkg::PH_LENLO: begin
          if (seg_len < 16'd2) begin
            res_valid  = 1'b1;
            res.status = dqtp_pkg::ST_OVERRUN;
          end else begin
            bytes_remaining_next = seg_len - 16'd2;
          end
        end
        dqtp_pkg::PH_INFO: begin
          bytes_remaining_next = rem_dec;
          current_table_next   = info_id;
          wide_entries_next    = info_wide;
          zigzag_position_next = 6'd0;
          if (info_overrun) begin
            res_valid    = 1'b1;
            res.status   = dqtp_pkg::ST_OVERRUN;
            res.table_id = info_id;
          end
        end
        dqtp_pkg::PH_ENTRY, dqtp_pkg::PH_LOW: begin
          bytes_remaining_next = rem_dec;
          if (phase == dqtp_pkg::PH_ENTRY && wide_entries) begin
            high_byte_next = seg_byte;
          end else begin
            res_valid        = 1'b1;
            res.status       = dqtp_pkg::ST_ENTRY;
            res.table_id     = current_table;
            res.entry_index  = dqtp_pkg::natural_of_zz(zigzag_position);
            res.entry_value  = (phase == dqtp_pkg::PH_LOW) ? {high_byte, seg_byte}
                                                           : {8'd0, seg_byte};
            res.table_last   = tab_end;
            res.segment_last = tab_end && (rem_dec == 16'd0);
            zigzag_position_next = tab_end ? 6'd0 : zigzag_position + 6'd1;
          end
        end
        default: ;
      endcase
    end
    res_valid = res_valid && byte_en;
  end

  // State registers; they move only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dqtp_pkg::PH_IDLE;
      bytes_remaining <= '0;
      current_table   <= '0;
      wide_entries    <= 1'b0;
      zigzag_position <= '0;
      high_byte       <= '0;
    end else if (byte_en) begin
      phase           <= phase_next;
      bytes_remaining <= bytes_remaining_next;
      current_table   <= current_table_next;
      wide_entries    <= wide_entries_next;
      zigzag_position <= zigzag_position_next;
      high_byte       <= high_byte_next;
    end
  end

endmodule

>>> sv/dqtp_queue.sv
// Back end: a small result queue that drives the output stream, so the
// parser keeps taking bytes while a result waits for the consumer.
module dqtp_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dqtp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output dqtp_pkg::result_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dqtp_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full      = count == CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/jpeg_dqt_segment_parser.sv
// DQT segment parser. Takes one segment byte per beat, checks the FF DB
// marker, reads the 16-bit length and then each table's info byte and its 64
// entries (8-bit, or 16-bit big-endian when the precision nibble is nonzero).
// Every entry comes out as one result beat with its table id and its natural
// row-major index; bad markers, length fields below 2 and tables that run
// past the segment length come out as status beats. The parser handles one
// byte per clock cycle, and the result queue of QUEUE_DEPTH entries (at
// least 2) keeps that rate while the output side takes one beat per cycle;
// the input stalls only when the queue is full.
module jpeg_dqt_segment_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] seg_byte
  input  logic [0:0]  s_axis_tuser,   // [0] seg_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] table_id, [9:4] entry_index,
                                      // [25:10] entry_value, zeros above
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] table_last
  output logic        m_axis_tlast    // segment_last
);

  logic              byte_en;
  logic              res_valid;
  logic              q_full;
  dqtp_pkg::result_t res;
  dqtp_pkg::result_t q_out;

  assign s_axis_tready = !q_full;
  assign byte_en       = s_axis_tvalid && s_axis_tready;

  // Front end: byte parser.
  dqtp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_en),
    .seg_byte  (s_axis_tdata),
    .seg_start (s_axis_tuser[0]),
    .res_valid (res_valid),
    .res       (res)
  );

  // Back end: result queue feeding the output stream.
  dqtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (q_out)
  );

  // Output packing.
  assign m_axis_tdata = {6'd0, q_out.entry_value, q_out.entry_index, q_out.table_id};
  assign m_axis_tuser = {q_out.table_last, q_out.status};
  assign m_axis_tlast = q_out.segment_last;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] seg_byte
  logic [0:0]  s_axis_tuser = 1'b0;   // [0] seg_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [3:0] table_id, [9:4] entry_index, [25:10] entry_value
  logic [2:0]  m_axis_tuser;          // [1:0] status, [2] table_last
  logic        m_axis_tlast;          // segment_last

  jpeg_dqt_segment_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // One row of the directed table. Typed rows carry their expected result.
  typedef struct {
    bit                start;
    logic [7:0]        data;
    bit                typed;
    bit                has;
    dqtp_pkg::result_t want;
  } dir_row_t;

  dqtp_pkg::result_t pending_results [$];
  dir_row_t   dir_rows [$];
  logic [5:0] zz_natural [64];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  // Shadow copy of the parser state.
  dqtp_pkg::phase_t parse_ph;
  logic [15:0] seg_left;
  logic [3:0] table_sel;
  logic       wide_sel;
  logic [5:0] zz_pos;
  logic [7:0] held_byte;

  // An entry beat: look up its natural index and advance the zigzag position.
  function automatic void emit_quant_entry(input logic [15:0] value,
                                           output dqtp_pkg::result_t r);
    r = '0;
    r.status       = dqtp_pkg::ST_ENTRY;
    r.table_id     = table_sel;
    r.entry_index  = zz_natural[zz_pos];
    r.entry_value  = value;
    r.table_last   = (zz_pos == dqtp_pkg::ZZ_LAST);
    r.segment_last = r.table_last && (seg_left == 16'd0);
    if (r.table_last) begin
      zz_pos   = 6'd0;
      parse_ph = (seg_left == 16'd0) ? dqtp_pkg::PH_IDLE : dqtp_pkg::PH_INFO;
    end else begin
      zz_pos   = zz_pos + 6'd1;
      parse_ph = dqtp_pkg::PH_ENTRY;
    end
  endfunction

  // Advances the shadow parser by one segment byte; returns 1 when a result is due.
  function automatic bit predict_dqt_byte(input bit start, input logic [7:0] b,
                                          output dqtp_pkg::result_t r);
    logic [15:0] seg_len;
    logic [15:0] need;
    r = '0;
    if (start) begin
      if (b != dqtp_pkg::MARK_FF) begin
        parse_ph = dqtp_pkg::PH_IDLE;
        r.status = dqtp_pkg::ST_BAD_MRK;
        return 1'b1;
      end
      parse_ph = dqtp_pkg::PH_MARK2;
      return 1'b0;
    end
    case (parse_ph)
      dqtp_pkg::PH_MARK2: begin
        if (b != dqtp_pkg::MARK_DQT) begin
          parse_ph = dqtp_pkg::PH_IDLE;
          r.status = dqtp_pkg::ST_BAD_MRK;
          return 1'b1;
        end
        parse_ph = dqtp_pkg::PH_LENHI;
      end
      dqtp_pkg::PH_LENHI: begin
        held_byte = b;
        parse_ph  = dqtp_pkg::PH_LENLO;
      end
      dqtp_pkg::PH_LENLO: begin
        seg_len = {held_byte, b};
        if (seg_len < 16'd2) begin
          parse_ph = dqtp_pkg::PH_IDLE;
          r.status = dqtp_pkg::ST_OVERRUN;
          return 1'b1;
        end
        seg_left = seg_len - 16'd2;
        parse_ph = (seg_left == 16'd0) ? dqtp_pkg::PH_IDLE : dqtp_pkg::PH_INFO;
      end
      dqtp_pkg::PH_INFO: begin
        if (seg_left != 16'd0) seg_left = seg_left - 16'd1;
        table_sel = 4'(b & dqtp_pkg::ID_MASK);
        wide_sel  = ((b & dqtp_pkg::PREC_MASK) != 8'h00);
        zz_pos    = 6'd0;
        need      = wide_sel ? dqtp_pkg::NEED_WIDE : dqtp_pkg::NEED_NARROW;
        if (seg_left < need) begin
          parse_ph   = dqtp_pkg::PH_IDLE;
          r.status   = dqtp_pkg::ST_OVERRUN;
          r.table_id = table_sel;
          return 1'b1;
        end
        parse_ph = dqtp_pkg::PH_ENTRY;
      end
      dqtp_pkg::PH_ENTRY: begin
        if (seg_left != 16'd0) seg_left = seg_left - 16'd1;
        if (wide_sel) begin
          held_byte = b;
          parse_ph  = dqtp_pkg::PH_LOW;
          return 1'b0;
        end
        emit_quant_entry({8'h00, b}, r);
        return 1'b1;
      end
      dqtp_pkg::PH_LOW: begin
        if (seg_left != 16'd0) seg_left = seg_left - 16'd1;
        emit_quant_entry({held_byte, b}, r);
        return 1'b1;
      end
      default: parse_ph = dqtp_pkg::PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Mostly random bytes, with the extremes showing up often.
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Presents one beat in bursts with random gaps and waits until it is taken.
  task automatic send_beat(input bit start, input logic [7:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(30, 90);
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(1, 10);
        gap_left   = $urandom_range(1, 5);
      end
    end
    while (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Sends one byte and files the result the shadow parser predicts for it.
  task automatic send_byte(input bit start, input logic [7:0] b);
    dqtp_pkg::result_t r;
    send_beat(start, b);
    if (predict_dqt_byte(start, b, r)) pending_results.insert(pending_results.size(), r);
    items_sent++;
  endtask

  // Holds the input off until every predicted result has come out.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Builds a DQT segment of ntab random tables. len_adj moves the length field
  // off the true body size; a positive slack is filled with extra bytes.
  // Only the first cut bytes are sent.
  task automatic send_dqt_segment(input int ntab, input int len_adj, input int cut);
    logic [7:0]  seg [$];
    logic [7:0]  info;
    logic [15:0] seg_len;
    int          body;
    for (int t = 0; t < ntab; t++) begin
      info[3:0] = 4'($urandom);
      info[7:4] = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
      seg.insert(seg.size(), info);
      repeat ((info[7:4] != 4'h0) ? 128 : 64) seg.insert(seg.size(), pick_byte());
    end
    body = seg.size();
    for (int i = 0; i < len_adj; i++) seg.insert(seg.size(), pick_byte());
    seg_len = 16'(2 + body + len_adj);
    seg.push_front(seg_len[7:0]);
    seg.push_front(seg_len[15:8]);
    seg.push_front(dqtp_pkg::MARK_DQT);
    seg.push_front(dqtp_pkg::MARK_FF);
    for (int i = 0; i < seg.size() && i < cut; i++) send_byte(i == 0, seg[i]);
  endtask

  task automatic add_row(input bit start, input logic [7:0] data, input bit typed,
                         input bit has, input logic [1:0] st, input logic [3:0] id,
                         input logic [15:0] val);
    dir_row_t row;
    row.start             = start;
    row.data              = data;
    row.typed             = typed;
    row.has               = has;
    row.want              = '0;
    row.want.status       = st;
    row.want.table_id     = id;
    row.want.entry_value  = val;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: stall pattern that steps through its four modes as the cycle count grows.
  always @(posedge clk) begin : rx_stall
    int mode;
    mode = (cycle_count >> 7) % 4;
    case (mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (cycle_count[2:0] != 3'd0);
    endcase
  end

  // Compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    dqtp_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got tdata %h tuser %h tlast %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(m_axis_tuser[1:0]));
        check_field("table_id", 16'(want.table_id), 16'(m_axis_tdata[3:0]));
        check_field("entry_index", 16'(want.entry_index), 16'(m_axis_tdata[9:4]));
        check_field("entry_value", want.entry_value, m_axis_tdata[25:10]);
        check_field("table_last", 16'(want.table_last), 16'(m_axis_tuser[2]));
        check_field("segment_last", 16'(want.segment_last), 16'(m_axis_tlast));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int      k;
    int      lo;
    int      hi;
    int      row;
    int      pick;
    int      ntab;
    bit      has;
    dqtp_pkg::result_t r;
    logic [7:0] b;

    // Zigzag order walks the anti-diagonals, turning direction on each one.
    k = 0;
    for (int s = 0; s < 15; s++) begin
      lo = (s > 7) ? s - 7 : 0;
      hi = (s < 7) ? s : 7;
      for (int i = lo; i <= hi; i++) begin
        row = (s % 2 == 1) ? i : lo + hi - i;
        zz_natural[k] = 6'(row * 8 + s - row);
        k++;
      end
    end

    parse_ph  = dqtp_pkg::PH_IDLE;
    seg_left  = 16'd0;
    table_sel = 4'd0;
    wide_sel  = 1'b0;
    zz_pos    = 6'd0;
    held_byte = 8'd0;

    // Directed rows: start, byte, typed, has result, status, table id, value.
    // Bad first marker byte right after reset.
    add_row(1'b1, 8'h00, 1'b1, 1'b1, dqtp_pkg::ST_BAD_MRK, 4'd0, 16'h0000);
    // A byte without start while idle is dropped.
    add_row(1'b0, 8'hFF, 1'b1, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    // Good first marker, bad second marker.
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h00, 1'b1, 1'b1, dqtp_pkg::ST_BAD_MRK, 4'd0, 16'h0000);
    // Length field of 1 is too short.
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hDB, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h01, 1'b1, 1'b1, dqtp_pkg::ST_OVERRUN, 4'd0, 16'h0000);
    // Empty segment: length 2 gives nothing.
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hDB, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h02, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    // A 16-bit table with only 63 bytes left overruns at its info byte.
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hDB, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h42, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'h1F, 1'b1, 1'b1, dqtp_pkg::ST_OVERRUN, 4'd15, 16'h0000);
    // Restart in the middle of a header, then the largest length.
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hDB, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b1, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hDB, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    // Narrow table 0; its first entry lands on natural index 0.
    add_row(1'b0, 8'h00, 1'b0, 1'b0, dqtp_pkg::ST_ENTRY, 4'd0, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b1, 1'b1, dqtp_pkg::ST_ENTRY, 4'd0, 16'h00FF);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].start, dir_rows[i].data);
      has = predict_dqt_byte(dir_rows[i].start, dir_rows[i].data, r);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has) pending_results.insert(pending_results.size(), dir_rows[i].want);
      end else if (has) begin
        pending_results.insert(pending_results.size(), r);
      end
    end
    wait_results_drained();

    // Random part: mostly well-formed segments, the rest broken ones and noise.
    while (items_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      ntab = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2);
      if (pick < 55) begin
        send_dqt_segment(ntab, 0, 1 << 20);
      end else if (pick < 65) begin
        // Length leaves slack, so a trailing table header overruns.
        send_dqt_segment(ntab, $urandom_range(1, 20), 1 << 20);
      end else if (pick < 75) begin
        // Length too small for the tables that follow.
        send_dqt_segment(ntab, -int'($urandom_range(1, 64)), 1 << 20);
      end else if (pick < 83) begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte(1'b1, 8'($urandom_range(0, 254)));
        end else begin
          b = 8'($urandom);
          if (b == dqtp_pkg::MARK_DQT) b = b ^ 8'h01;
          send_byte(1'b1, dqtp_pkg::MARK_FF);
          send_byte(1'b0, b);
        end
      end else if (pick < 90) begin
        // Cut short; the next segment start abandons it.
        send_dqt_segment(ntab, 0, $urandom_range(5, 150));
      end else if (pick < 95) begin
        // Length fields of 0, 1 and 2.
        send_dqt_segment(0, -int'($urandom_range(0, 2)), 1 << 20);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(1'b0, pick_byte());
      end
      if ($urandom_range(0, 7) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
